FILE: src/prefix_varint_decoder_defines.svh
// ------------------------------------------------------------------------
// prefix varint decoder assertion macros
// shared concurrent assertion forms for the port checker
// ------------------------------------------------------------------------
`ifndef PREFIX_VARINT_DECODER_DEFINES_SVH
`define PREFIX_VARINT_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PVD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PVD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/pvd_pkg.sv
// ------------------------------------------------------------------------
// pvd_pkg
// widths, constants and shared types of the prefix varint decoder
// ------------------------------------------------------------------------
package pvd_pkg;

	localparam int BYTE_W  = 8;
	localparam int VALUE_W = 64;
	localparam int LEN_W   = 4;

	localparam int TOP_BIT = BYTE_W - 1;

	// length of the form with a zero first byte: one prefix and eight raw bytes
	localparam logic [LEN_W-1:0] LONG_FORM_LEN = LEN_W'(9);
	localparam logic [LEN_W-1:0] SHORT_LEN     = LEN_W'(1);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [LEN_W-1:0]   length;
	} pvd_result_t;

endpackage

FILE: src/prefix_varint_decoder.sv
// a varint's last byte passes the input register before its result is registered
// throughput: one byte per cycle unless the output stalls; the accumulator shift
// and prefix decode sit between the input register and the result register
// reset: arst_n clears the handshakes, the accumulator, byte counts and
// signed_mode (unsigned decode)
// ------------------------------------------------------------------------
// prefix_varint_decoder
// decodes a byte stream of unary length prefixed varints into 64-bit values
// ------------------------------------------------------------------------
module prefix_varint_decoder
	import pvd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BYTE_W-1:0]  in_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VALUE_W-1:0] value,
	output logic [LEN_W-1:0]   length
);

	logic              signed_mode_q;
	logic              byte_valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              emit;
	pvd_result_t       result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			signed_mode_q <= cfg_data;
		end
	end

	// a held word moves on whenever the result register is free or draining
	assign advance = byte_valid_s1 && (!out_valid || out_ready);

	pvd_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.advance       (advance),
		.byte_valid_s1 (byte_valid_s1),
		.byte_s1       (byte_s1)
	);

	pvd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.byte_s1     (byte_s1),
		.signed_mode (signed_mode_q),
		.emit        (emit),
		.result      (result)
	);

	pvd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.emit      (emit),
		.result    (result),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.length    (length)
	);

endmodule

FILE: src/pvd_in_stage.sv
// ------------------------------------------------------------------------
// pvd_in_stage
// input register holding one stream byte until the decoder takes it
// ------------------------------------------------------------------------
module pvd_in_stage
	import pvd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              advance,
	output logic              byte_valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	// refill in the same cycle the held word moves on
	assign in_ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			byte_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

FILE: src/pvd_core.sv
// ------------------------------------------------------------------------
// pvd_core
// length prefix decode, big-endian accumulation and sign unfolding
// ------------------------------------------------------------------------
module pvd_core
	import pvd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [BYTE_W-1:0] byte_s1,
	input  logic              signed_mode,
	output logic              emit,
	output pvd_result_t       result
);

	logic [LEN_W-1:0]   bytes_left_q;
	logic [VALUE_W-1:0] acc_q;
	logic [LEN_W-1:0]   total_len_q;

	logic [LEN_W-1:0]   bytes_left_n;
	logic [VALUE_W-1:0] acc_n;
	logic [LEN_W-1:0]   total_len_n;
	logic [VALUE_W-1:0] shifted;

	logic [2:0]         marker_pos;
	logic [LEN_W-1:0]   lead_zeros;
	logic [BYTE_W-1:0]  marker_mask;

	// highest set bit of the first byte below the top bit
	always_comb begin
		marker_pos = 3'd0;
		for (int i = 0; i < TOP_BIT; i++) begin
			if (byte_s1[i]) begin
				marker_pos = 3'(i);
			end
		end
	end

	assign lead_zeros  = LEN_W'(TOP_BIT) - LEN_W'(marker_pos);
	assign marker_mask = ~(BYTE_W'(1) << marker_pos);

	always_comb begin
		bytes_left_n = bytes_left_q;
		acc_n        = acc_q;
		total_len_n  = total_len_q;
		emit         = 1'b0;
		if (bytes_left_q != '0) begin
			acc_n        = {acc_q[VALUE_W-BYTE_W-1:0], byte_s1};
			bytes_left_n = bytes_left_q - LEN_W'(1);
			emit         = (bytes_left_q == LEN_W'(1));
		end else if (byte_s1[TOP_BIT]) begin
			acc_n        = VALUE_W'(byte_s1[TOP_BIT-1:0]);
			total_len_n  = SHORT_LEN;
			emit         = 1'b1;
		end else if (byte_s1 == '0) begin
			acc_n        = '0;
			total_len_n  = LONG_FORM_LEN;
			bytes_left_n = LONG_FORM_LEN - LEN_W'(1);
		end else begin
			acc_n        = VALUE_W'(byte_s1 & marker_mask);
			total_len_n  = lead_zeros + LEN_W'(1);
			bytes_left_n = lead_zeros;
		end
	end

	// zigzag style unfolding: sign in bit 0
	assign shifted       = acc_n >> 1;
	assign result.value  = !signed_mode ? acc_n : (acc_n[0] ? ~shifted : shifted);
	assign result.length = total_len_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			acc_q        <= '0;
			total_len_q  <= '0;
		end else if (advance) begin
			if (emit) begin
				bytes_left_q <= '0;
				acc_q        <= '0;
				total_len_q  <= '0;
			end else begin
				bytes_left_q <= bytes_left_n;
				acc_q        <= acc_n;
				total_len_q  <= total_len_n;
			end
		end
	end

endmodule

FILE: src/pvd_out_stage.sv
// ------------------------------------------------------------------------
// pvd_out_stage
// result register on the output handshake
// ------------------------------------------------------------------------
module pvd_out_stage
	import pvd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               emit,
	input  pvd_result_t        result,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VALUE_W-1:0] value,
	output logic [LEN_W-1:0]   length
);

	logic        valid_q;
	pvd_result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= emit;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign value     = res_q.value;
	assign length    = res_q.length;

endmodule

FILE: src/pvd_checker.sv
// ------------------------------------------------------------------------
// pvd_checker
// port level checks of the prefix varint decoder, bound to the top level
// ------------------------------------------------------------------------
`include "prefix_varint_decoder_defines.svh"

module pvd_checker
	import pvd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [VALUE_W-1:0] value,
	input logic [LEN_W-1:0]   length
);

	// a stalled result stays up
	`PVD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid,
		"result dropped while stalled")

	// a stalled result keeps its payload
	`PVD_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready,
		$stable(value) && $stable(length), "result changed while stalled")

	// an empty result register never blocks the input
	`PVD_ASSERT_IMP(a_in_free, clk, arst_n, !out_valid, in_ready,
		"input blocked with no result pending")

	// shown length is always a legal varint size
	`PVD_ASSERT_IMP(a_len_range, clk, arst_n, out_valid,
		(length >= SHORT_LEN) && (length <= LONG_FORM_LEN), "result length out of range")

	// a fresh result follows an earlier accepted word
	`PVD_ASSERT_IMP(a_out_cause, clk, arst_n, $rose(out_valid),
		$past(in_valid && in_ready, 2), "result without a preceding word")

endmodule

bind prefix_varint_decoder pvd_checker u_pvd_checker (.*);

FILE: tb/tb.sv
// ------------------------------------------------------------------------
// tb
// self-checking bench for the prefix varint decoder: a directed table of
// boundary streams, then random back-to-back varints with both decode modes,
// each output word checked against the table's value or a behavioural decoder kept in the bench
// ------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pvd_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 4;
	localparam int SEG_BYTES    = 315;
	localparam int NUM_SEGS     = 6;
	localparam int NUM_ROWS     = 25;

	typedef struct {
		bit                 set_mode;
		bit                 mode;
		logic [BYTE_W-1:0]  b;
		bit                 typed;
		logic [VALUE_W-1:0] v;
		logic [LEN_W-1:0]   len;
	} stim_row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_data  = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [BYTE_W-1:0]  in_byte   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [VALUE_W-1:0] value;
	logic [LEN_W-1:0]   length;

	// decoder state mirrored by the bench
	logic [LEN_W-1:0]   pend_bytes;
	logic [VALUE_W-1:0] acc_bits;
	logic [LEN_W-1:0]   run_len;
	bit                 mode_now;

	pvd_result_t decoded_q[$];
	int          err_count;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_idle_pct;

	// sign flag sits in bit 0, mode is sampled when the word completes
	stim_row_t stim_rows [NUM_ROWS] = '{
		'{1, 0, 8'h80, 1, 64'd0, 4'd1},
		'{0, 0, 8'hFF, 1, 64'd127, 4'd1},
		'{0, 0, 8'h7F, 0, 64'd0, 4'd0},
		'{0, 0, 8'hFF, 1, 64'h3FFF, 4'd2},
		'{0, 0, 8'h01, 0, 64'd0, 4'd0},
		'{0, 0, 8'hAA, 0, 64'd0, 4'd0},
		'{0, 0, 8'hAA, 0, 64'd0, 4'd0},
		'{0, 0, 8'hAA, 0, 64'd0, 4'd0},
		'{0, 0, 8'hAA, 0, 64'd0, 4'd0},
		'{0, 0, 8'hAA, 0, 64'd0, 4'd0},
		'{0, 0, 8'hAA, 0, 64'd0, 4'd0},
		'{0, 0, 8'hAA, 0, 64'd0, 4'd0},
		'{0, 0, 8'h00, 0, 64'd0, 4'd0},
		'{0, 0, 8'hFF, 0, 64'd0, 4'd0},
		'{0, 0, 8'hFF, 0, 64'd0, 4'd0},
		'{0, 0, 8'hFF, 0, 64'd0, 4'd0},
		'{0, 0, 8'hFF, 0, 64'd0, 4'd0},
		'{0, 0, 8'hFF, 0, 64'd0, 4'd0},
		'{0, 0, 8'hFF, 0, 64'd0, 4'd0},
		'{0, 0, 8'hFF, 0, 64'd0, 4'd0},
		'{0, 0, 8'hFF, 1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9},
		'{1, 1, 8'h81, 1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1},
		'{0, 1, 8'hFE, 1, 64'd63, 4'd1},
		'{0, 1, 8'h40, 0, 64'd0, 4'd0},
		'{1, 0, 8'h05, 0, 64'd0, 4'd0}
	};

	prefix_varint_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.length    (length)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= LIMIT_CYCLES);
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output pvd_result_t word);
		int                 lz;
		logic [BYTE_W-1:0]  marker;
		logic [VALUE_W-1:0] v;
		bit                 neg;
		bit                 done;

		done = 1'b0;
		word = '0;
		if (pend_bytes != 0) begin
			acc_bits   = {acc_bits[VALUE_W-BYTE_W-1:0], b};
			pend_bytes = pend_bytes - 1'b1;
			done       = (pend_bytes == 0);
		end else if (b[TOP_BIT]) begin
			acc_bits = VALUE_W'(b[TOP_BIT-1:0]);
			run_len  = SHORT_LEN;
			done     = 1'b1;
		end else if (b == '0) begin
			acc_bits   = '0;
			run_len    = LONG_FORM_LEN;
			pend_bytes = LONG_FORM_LEN - 1'b1;
		end else begin
			lz     = 1;
			marker = 8'h40;
			while ((b & marker) == '0) begin
				lz++;
				marker = marker >> 1;
			end
			acc_bits   = VALUE_W'(b & ~marker);
			run_len    = LEN_W'(lz + 1);
			pend_bytes = LEN_W'(lz);
		end
		if (done) begin
			v = acc_bits;
			if (mode_now) begin
				neg = v[0];
				v   = v >> 1;
				if (neg)
					v = ~v;
			end
			word.value  = v;
			word.length = run_len;
			pend_bytes  = '0;
			acc_bits    = '0;
			run_len     = '0;
		end
		return done;
	endfunction

	task automatic note_mismatch(input string what);
		if (err_count < 10)
			$display("mismatch: %s", what);
		err_count++;
	endtask

	always @(posedge clk) begin : check_words
		pvd_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				note_mismatch($sformatf("unexpected word value %h length %0d", value, length));
			end else begin
				want = decoded_q.pop_front();
				if (value !== want.value)
					note_mismatch($sformatf("value exp %h got %h", want.value, value));
				if (length !== want.length)
					note_mismatch($sformatf("length exp %0d got %0d", want.length, length));
			end
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b, input bit use_typed,
			input pvd_result_t typed_word);
		pvd_result_t word;
		bit          got;

		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		got = decode_byte(b, word);
		if (use_typed)
			decoded_q.push_back(typed_word);
		else if (got)
			decoded_q.push_back(word);
	endtask

	// stop sending, let every pending word out, then allow the pipe to settle
	task automatic drain_words();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		drain_words();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_now = m;
	endtask

	initial begin : stimulus
		pvd_result_t       typed_word;
		int                seg_count;
		int                k;
		logic [BYTE_W-1:0] marker;
		logic [BYTE_W-1:0] b;

		pend_bytes    = '0;
		acc_bits      = '0;
		run_len       = '0;
		mode_now      = 1'b0;
		err_count     = 0;
		cycle_count   = 0;
		send_idle_pct = 31;
		recv_idle_pct = 49;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].set_mode)
				write_mode(stim_rows[i].mode);
			typed_word.value  = stim_rows[i].v;
			typed_word.length = stim_rows[i].len;
			push_byte(stim_rows[i].b, stim_rows[i].typed, typed_word);
		end

		typed_word = '0;
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 49;
				end
				1: begin
					send_idle_pct = 49;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (seg == 0)
				write_mode(1'b1);
			else if (seg == 1)
				write_mode(1'b0);
			else
				write_mode(1'($urandom_range(1)));

			seg_count = 0;
			while (seg_count < SEG_BYTES) begin
				if ($urandom_range(199) == 0)
					drain_words();
				if ($urandom_range(99) < 10) begin
					// arbitrary noise byte, may cut into the stream anywhere
					push_byte(8'($urandom_range(255)), 1'b0, typed_word);
					seg_count++;
				end else begin
					k = $urandom_range(1, 9);
					if (k == 1) begin
						b = 8'h80 | 8'($urandom_range(255));
					end else if (k == 9) begin
						b = 8'h00;
					end else begin
						marker = 8'h80 >> (k - 1);
						b = marker | (8'($urandom_range(255)) & (marker - 1'b1));
					end
					push_byte(b, 1'b0, typed_word);
					for (int j = 1; j < k; j++) begin
						case ($urandom_range(7))
							0: b = 8'h00;
							1: b = 8'hFF;
							default: b = 8'($urandom_range(255));
						endcase
						push_byte(b, 1'b0, typed_word);
					end
					seg_count += k;
				end
			end
		end

		drain_words();
		if (err_count == 0 && decoded_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/pvd_pkg.sv
src/pvd_in_stage.sv
src/pvd_core.sv
src/pvd_out_stage.sv
src/prefix_varint_decoder.sv
src/pvd_checker.sv
tb/tb.sv
